// File: rtl/core/apad_pkg.sv
// Package for the arc point-at-distance core: shared constants, register
// indexes and the CORDIC arctangent table. Depends on nothing.
`default_nettype none
package apad_pkg;

    // Default parameter values.
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_START_DISTANCE = 3'd0;
    localparam logic [2:0] REG_START_X        = 3'd1;
    localparam logic [2:0] REG_START_Y        = 3'd2;
    localparam logic [2:0] REG_START_HEADING  = 3'd3;
    localparam logic [2:0] REG_ARC_CURVATURE  = 3'd4;

    // Turn-rate constant 2^29/pi split into integer and fraction parts.
    localparam logic [27:0] RATE_HI      = 28'd170891318;
    localparam logic [31:0] RATE_LO      = 32'd3840164173;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // CORDIC datapath.
    localparam int          CORDIC_W    = 34;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

    // Radius divider: 35-bit dividend, one quotient bit a cycle.
    localparam int DIV_STEPS = 35;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/apad_query_if.sv
// Query channel: valid/ready handshake carrying one road distance per item.
// Depends on nothing.
`default_nettype none
interface apad_query_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] query_distance;

    modport source (output valid, output query_distance, input ready);
    modport sink   (input valid, input query_distance, output ready);
endinterface
`default_nettype wire

// File: rtl/core/apad_point_if.sv
// Result channel: valid/ready handshake carrying one arc point per item.
// Depends on nothing.
`default_nettype none
interface apad_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [15:0] point_heading;

    modport source (output valid, output point_x, output point_y, output point_heading,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_heading,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/core/apad_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a 32-bit turn angle.
// Depends on apad_pkg for the gain and the arctangent table.
`default_nettype none
module apad_cordic #(
    parameter int CORDIC_STAGES = apad_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_vld,
    input  wire logic        [31:0]                    i_angle,
    output logic                                       o_vld,
    output logic signed [apad_pkg::CORDIC_W-1:0]       o_cos,
    output logic signed [apad_pkg::CORDIC_W-1:0]       o_sin
);
    localparam int W = apad_pkg::CORDIC_W;

    logic               r_v [0:CORDIC_STAGES];
    logic signed [W-1:0] r_x [0:CORDIC_STAGES];
    logic signed [W-1:0] r_y [0:CORDIC_STAGES];
    logic signed [32:0]  r_z [0:CORDIC_STAGES];
    logic        [1:0]   r_q [0:CORDIC_STAGES];

    logic signed [32:0] pre_z;
    logic        [1:0]  pre_q;

    // Fold the residual angle into half a quadrant either side of zero.
    always_comb begin
        pre_z = $signed({3'b000, i_angle[29:0]});
        pre_q = i_angle[31:30];
        if (i_angle[29]) begin
            pre_z = pre_z - 33'sd1073741824;
            pre_q = pre_q + 2'd1;
        end
    end

    // Valid bits of each stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_STAGES; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
            for (int i = 0; i < CORDIC_STAGES; i++) r_v[i+1] <= r_v[i];
        end
    end

    // Rotation stages, one micro-rotation each.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(apad_pkg::CORDIC_GAIN);
            r_y[0] <= '0;
            r_z[0] <= pre_z;
            r_q[0] <= pre_q;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({1'b0, apad_pkg::atan_turn(i)});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({1'b0, apad_pkg::atan_turn(i)});
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // Map the result back to its quadrant.
    always_comb begin
        case (r_q[CORDIC_STAGES])
            2'd1: begin
                o_cos = -r_y[CORDIC_STAGES];
                o_sin =  r_x[CORDIC_STAGES];
            end
            2'd2: begin
                o_cos = -r_x[CORDIC_STAGES];
                o_sin = -r_y[CORDIC_STAGES];
            end
            2'd3: begin
                o_cos =  r_y[CORDIC_STAGES];
                o_sin = -r_x[CORDIC_STAGES];
            end
            default: begin
                o_cos =  r_x[CORDIC_STAGES];
                o_sin =  r_y[CORDIC_STAGES];
            end
        endcase
    end

    assign o_vld = r_v[CORDIC_STAGES];

endmodule
`default_nettype wire

// File: rtl/core/arc_point_at_distance_core.sv
// Circular arc evaluated at a queried road distance: config registers, radius
// divider, sweep multiplier, two CORDIC units and the offset pipeline.
// Depends on apad_pkg, apad_query_if, apad_point_if and apad_cordic.
// Throughput: one item per cycle; the whole pipeline holds when a result is stalled.
// After reset and after each register write the input is held not ready while
// the radius divider and start CORDIC settle.
// Reset is synchronous, active low, and clears the configuration registers and valid bits.
`default_nettype none
module arc_point_at_distance_core #(
    parameter int ANGLE_BITS    = apad_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = apad_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    apad_query_if.sink       i_query,
    apad_point_if.source     o_point,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int W      = apad_pkg::CORDIC_W;
    localparam int CLAT   = CORDIC_STAGES + 1;
    localparam int SETTLE = apad_pkg::DIV_STEPS + CORDIC_STAGES + 6;
    localparam int SW     = $clog2(SETTLE + 1);
    localparam int DCW    = $clog2(apad_pkg::DIV_STEPS + 1);
    localparam logic [31:0] HALF_LSB = 32'd1 << (31 - ANGLE_BITS);

    // Configuration registers.
    logic signed [31:0] r_start_distance, r_start_x, r_start_y, r_arc_curvature;
    logic        [15:0] r_start_heading;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_distance <= '0;
            r_start_x        <= '0;
            r_start_y        <= '0;
            r_start_heading  <= '0;
            r_arc_curvature  <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                apad_pkg::REG_START_DISTANCE: r_start_distance <= pwdata;
                apad_pkg::REG_START_X:        r_start_x        <= pwdata;
                apad_pkg::REG_START_Y:        r_start_y        <= pwdata;
                apad_pkg::REG_START_HEADING:  r_start_heading  <= pwdata[15:0];
                apad_pkg::REG_ARC_CURVATURE:  r_arc_curvature  <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            apad_pkg::REG_START_DISTANCE: prdata = r_start_distance;
            apad_pkg::REG_START_X:        prdata = r_start_x;
            apad_pkg::REG_START_Y:        prdata = r_start_y;
            apad_pkg::REG_START_HEADING:  prdata = {16'd0, r_start_heading};
            apad_pkg::REG_ARC_CURVATURE:  prdata = r_arc_curvature;
            default:                      prdata = '0;
        endcase
    end

    // Quantities derived from the configuration alone.
    logic [31:0] mag;
    logic [31:0] hdg, start_ang;
    assign mag = r_arc_curvature[31] ? 32'(-r_arc_curvature) : r_arc_curvature;
    assign hdg = 32'(ANGLE_BITS'(r_start_heading)) << (32 - ANGLE_BITS);
    assign start_ang = (r_arc_curvature[31] || (r_arc_curvature == '0))
                       ? hdg + apad_pkg::QUARTER_TURN : hdg - apad_pkg::QUARTER_TURN;

    // Turn rate, two registered steps.
    logic [59:0] r_p_hi;
    logic [63:0] r_p_lo;
    logic [63:0] r_kt;
    logic [59:0] kt_mag;
    assign kt_mag = r_p_hi + 60'((65'(r_p_lo) + 65'h0_8000_0000) >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_hi <= '0;
            r_p_lo <= '0;
            r_kt   <= '0;
        end else begin
            r_p_hi <= 60'(mag * apad_pkg::RATE_HI);
            r_p_lo <= 64'(mag * apad_pkg::RATE_LO);
            r_kt   <= r_arc_curvature[31] ? 64'(-64'(kt_mag)) : 64'(kt_mag);
        end
    end

    // Settle counter and restoring divider for the radius 2^34/|k|.
    logic [SW-1:0]  r_settle;
    logic           r_div_go;
    logic [DCW-1:0] r_div_cnt;
    logic [34:0]    r_num, r_quo;
    logic [31:0]    r_rem;
    logic [30:0]    r_radius;
    logic [32:0]    rem_sh;
    logic           rem_ge;

    assign rem_sh = {r_rem, r_num[34]};
    assign rem_ge = rem_sh >= {1'b0, mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle  <= SW'(SETTLE);
            r_div_go  <= 1'b1;
            r_div_cnt <= '0;
        end else begin
            r_div_go <= cfg_wr;
            if (cfg_wr) r_settle <= SW'(SETTLE);
            else if (r_settle != '0) r_settle <= r_settle - SW'(1);
            if (r_div_go) r_div_cnt <= DCW'(apad_pkg::DIV_STEPS);
            else if (r_div_cnt != '0) r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_go) begin
            r_num <= {1'b1, 34'd0} + 35'(mag >> 1);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_div_cnt != '0) begin
            r_num <= r_num << 1;
            r_rem <= rem_ge ? 32'(rem_sh - {1'b0, mag}) : rem_sh[31:0];
            r_quo <= {r_quo[33:0], rem_ge};
        end
        if (mag == '0) r_radius <= '0;
        else if (r_quo > 35'h0_7FFF_FFFF) r_radius <= 31'h7FFF_FFFF;
        else r_radius <= r_quo[30:0];
    end

    // Start point on the circle, constant while items flow.
    logic signed [W-1:0] c0, s0;
    apad_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_vld   (1'b0),
        .i_angle (start_ang),
        .o_vld   (),
        .o_cos   (c0),
        .o_sin   (s0)
    );

    // Pipeline enable: advance unless a finished result is stalled.
    logic en;
    assign en = !o_point.valid || o_point.ready;
    assign i_query.ready = en && (r_settle == '0);

    // S1: travelled distance.  S2: partial products.  S3: end angle and heading.
    logic               r1_v, r2_v, r3_v;
    logic signed [32:0] r1_d;
    logic signed [65:0] r2_p1;
    logic        [31:0] r2_p2;
    logic        [31:0] r3_end;
    logic        [15:0] r3_hout;
    logic        [31:0] sweep;

    assign sweep = r2_p1[63:32] + r2_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_query.valid && i_query.ready;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= 33'(i_query.query_distance) - 33'(r_start_distance);
            r2_p1   <= r1_d * $signed({1'b0, r_kt[31:0]});
            r2_p2   <= 32'(r1_d[31:0] * r_kt[63:32]);
            r3_end  <= start_ang + sweep;
            r3_hout <= 16'((hdg + sweep + HALF_LSB) >> (32 - ANGLE_BITS));
        end
    end

    // End point on the circle, with the heading carried alongside.
    logic               c_vld;
    logic signed [W-1:0] c1, s1;
    logic        [15:0] r_hd [0:CLAT-1];

    apad_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_end (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_v),
        .i_angle (r3_end),
        .o_vld   (c_vld),
        .o_cos   (c1),
        .o_sin   (s1)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd[0] <= r3_hout;
            for (int j = 1; j < CLAT; j++) r_hd[j] <= r_hd[j-1];
        end
    end

    // S4: chord differences.  S5: scale by radius.  S6: round, offset, saturate.
    logic               r4_v, r5_v;
    logic signed [W:0]  r4_dx, r4_dy;
    logic        [15:0] r4_hd, r5_hd;
    logic signed [W+32:0] r5_mx, r5_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v          <= 1'b0;
            r5_v          <= 1'b0;
            o_point.valid <= 1'b0;
        end else if (en) begin
            r4_v          <= c_vld;
            r5_v          <= r4_v;
            o_point.valid <= r5_v;
        end
    end

    function automatic logic signed [31:0] place(input logic signed [W+32:0] m,
                                                 input logic signed [31:0] base);
        logic signed [W+32:0] rnd;
        logic signed [37:0]   sum;
        rnd = (m + (W+33)'(64'sd536870912)) >>> 30;
        sum = 38'(rnd) + 38'(base);
        if (sum > 38'sd2147483647) return 32'sh7FFF_FFFF;
        if (sum < -38'sd2147483648) return 32'sh8000_0000;
        return sum[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dx <= (W+1)'(c1) - (W+1)'(c0);
            r4_dy <= (W+1)'(s1) - (W+1)'(s0);
            r4_hd <= r_hd[CLAT-1];
            r5_mx <= $signed({1'b0, r_radius}) * r4_dx;
            r5_my <= $signed({1'b0, r_radius}) * r4_dy;
            r5_hd <= r4_hd;
            o_point.point_x       <= place(r5_mx, r_start_x);
            o_point.point_y       <= place(r5_my, r_start_y);
            o_point.point_heading <= r5_hd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/apad_checker.sv
// Port-level checker for the arc point core, bound to the top level.
// Depends on arc_point_at_distance_core and its interfaces.
`default_nettype none
module apad_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic q_ready,
    input wire logic p_valid,
    input wire logic p_ready,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite
);
    // A stalled result item stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_valid && !p_ready |=> p_valid)
        else $error("result item dropped while stalled");

    // A register write holds off new items while derived values settle.
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |=> !q_ready)
        else $error("query accepted right after a register write");

    // With the result stalled the pipeline is frozen and takes no item.
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_valid && !p_ready |-> !q_ready)
        else $error("query accepted while the pipeline is frozen");

    // Reset leaves the core unready for the settle time.
    a_reset_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !q_ready)
        else $error("query ready straight after reset");

endmodule

bind arc_point_at_distance_core apad_checker u_apad_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .q_ready (i_query.ready),
    .p_valid (o_point.valid),
    .p_ready (o_point.ready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite)
);
`default_nettype wire
